/* src/brsp_pkg.sv */
// Package for the block record stream parser.
// Holds the item types, field and verdict codes, and the fixed field lengths.
// No dependencies.
package brsp_pkg;

  localparam int SEP_LEN = 4;

  localparam logic [5:0] F_VERSION    = 6'd0;
  localparam logic [5:0] F_STATE_ROOT = 6'd6;
  localparam logic [5:0] F_FLAG       = 6'd8;
  localparam logic [5:0] F_FORMAT     = 6'd9;
  localparam logic [5:0] F_FP_LEN     = 6'd11;
  localparam logic [5:0] F_FP_BYTES   = 6'd12;
  localparam logic [5:0] F_TITLE_LEN  = 6'd14;
  localparam logic [5:0] F_TITLE      = 6'd15;
  localparam logic [5:0] F_ARTIST_LEN = 6'd16;
  localparam logic [5:0] F_ARTIST     = 6'd17;
  localparam logic [5:0] F_GENRE_LEN  = 6'd19;
  localparam logic [5:0] F_GENRE      = 6'd20;
  localparam logic [5:0] F_ALBUM_LEN  = 6'd21;
  localparam logic [5:0] F_ALBUM      = 6'd22;
  localparam logic [5:0] F_ROY_COUNT  = 6'd25;
  localparam logic [5:0] F_SPLIT_ADDR = 6'd26;
  localparam logic [5:0] F_SPLIT_BP   = 6'd27;
  localparam logic [5:0] F_SEP        = 6'd28;
  localparam logic [5:0] F_TX_COUNT   = 6'd29;
  localparam logic [5:0] F_TX_LEN     = 6'd30;
  localparam logic [5:0] F_TX_BYTES   = 6'd31;
  localparam logic [5:0] F_IGNORED    = 6'd32;

  localparam logic [1:0] ST_PARSING  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_BAD_SEP  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  field_code;
    logic [7:0]  data_out;
    logic [31:0] item_index;
    logic [1:0]  verdict;
    logic        frame_done;
  } out_item_t;

  // Byte length of each field; zero means the length comes from the last prefix.
  function automatic logic [5:0] fixed_len(input logic [5:0] f);
    logic [5:0] len;
    case (f)
      6'd0, 6'd13, 6'd29, 6'd30: len = 6'd4;
      6'd1, 6'd2, 6'd3, 6'd4, 6'd6, 6'd7, 6'd10: len = 6'd32;
      6'd5: len = 6'd8;
      6'd8, 6'd9, 6'd25: len = 6'd1;
      6'd11, 6'd14, 6'd16, 6'd19, 6'd21, 6'd23, 6'd24, 6'd27: len = 6'd2;
      6'd18, 6'd26: len = 6'd20;
      6'd28: len = 6'(SEP_LEN);
      default: len = 6'd0;
    endcase
    return len;
  endfunction

  function automatic logic is_prefix(input logic [5:0] f);
    return f == F_FP_LEN || f == F_TITLE_LEN || f == F_ARTIST_LEN ||
           f == F_GENRE_LEN || f == F_ALBUM_LEN || f == F_TX_COUNT || f == F_TX_LEN;
  endfunction

  function automatic logic is_body(input logic [5:0] f);
    return f == F_FP_BYTES || f == F_TITLE || f == F_ARTIST ||
           f == F_GENRE || f == F_ALBUM;
  endfunction

endpackage

/* src/brsp_parse.sv */
// Parser state and the per-item field tagging logic.
// Depends on brsp_pkg for item types, field codes and field lengths.
module brsp_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          separator_byte,
  input  brsp_pkg::in_item_t  item,
  output brsp_pkg::out_item_t result
);
  import brsp_pkg::*;

  logic [5:0]  field_now, field_now_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] length_hold, length_hold_next;
  logic [31:0] version_hold, version_hold_next;
  logic        song_present, song_present_next;
  logic [31:0] items_left, items_left_next;
  logic [7:0]  splits_left, splits_left_next;
  logic [31:0] item_number, item_number_next;
  logic [1:0]  status_hold, status_hold_next;

  logic        active;
  logic [4:0]  shift_amt;
  logic [31:0] byte_word;
  logic [31:0] merged_ver;
  logic [31:0] merged_len;
  logic [5:0]  flen;
  logic [31:0] len_cur;
  logic [32:0] count_inc;
  logic [5:0]  target;
  logic [1:0]  verdict;

  always_comb begin
    field_now_next    = field_now;
    byte_count_next   = byte_count;
    length_hold_next  = length_hold;
    version_hold_next = version_hold;
    song_present_next = song_present;
    items_left_next   = items_left;
    splits_left_next  = splits_left;
    item_number_next  = item_number;
    status_hold_next  = status_hold;
    target            = F_IGNORED;

    active     = item.byte_present && !field_now[5] && status_hold == ST_PARSING;
    byte_word  = {24'd0, item.data_byte};
    shift_amt  = {byte_count[1:0], 3'b000};
    merged_ver = (byte_count == 32'd0) ? byte_word : (version_hold | (byte_word << shift_amt));
    merged_len = (byte_count == 32'd0) ? byte_word : (length_hold | (byte_word << shift_amt));
    flen       = fixed_len(field_now);
    count_inc  = {1'b0, byte_count} + 33'd1;
    len_cur    = 32'd0;

    if (active) begin
      if (field_now == F_SEP && item.data_byte != separator_byte) begin
        status_hold_next = ST_BAD_SEP;
        field_now_next   = F_IGNORED;
      end else begin
        if (field_now == F_VERSION) version_hold_next = merged_ver;
        if (is_prefix(field_now)) length_hold_next = merged_len;
        if (field_now == F_FLAG) song_present_next = item.data_byte != 8'd0;
        if (field_now == F_ROY_COUNT) splits_left_next = item.data_byte;
        len_cur = (flen == 6'd0) ? length_hold_next : {26'd0, flen};
        if (count_inc < {1'b0, len_cur}) begin
          byte_count_next = count_inc[31:0];
        end else begin
          case (field_now)
            F_ROY_COUNT: begin
              item_number_next = 32'd0;
              target           = F_SPLIT_ADDR;
            end
            F_SPLIT_BP: begin
              splits_left_next = splits_left - 8'd1;
              item_number_next = item_number + 32'd1;
              target           = F_SPLIT_ADDR;
            end
            F_TX_COUNT: begin
              items_left_next  = length_hold_next;
              item_number_next = 32'd0;
              target           = F_TX_LEN;
            end
            F_TX_BYTES: begin
              items_left_next  = items_left - 32'd1;
              item_number_next = item_number + 32'd1;
              target           = F_TX_LEN;
            end
            default: begin
              target = field_now + 6'd1;
            end
          endcase
          // Skip fields that are absent or have zero length.
          if (target == F_STATE_ROOT && version_hold_next[31:2] == 30'd0) begin
            target = F_FLAG;
          end else if (target == F_FORMAT && !song_present_next) begin
            target = F_SEP;
          end else if (is_body(target) && length_hold_next == 32'd0) begin
            target = target + 6'd1;
          end else if (target == F_SPLIT_ADDR && splits_left_next == 8'd0) begin
            target = F_SEP;
          end else if (target == F_TX_BYTES && length_hold_next == 32'd0) begin
            items_left_next  = items_left - 32'd1;
            item_number_next = item_number + 32'd1;
            target           = F_TX_LEN;
          end
          if (target == F_TX_LEN && items_left_next == 32'd0) target = F_IGNORED;
          field_now_next  = target;
          byte_count_next = 32'd0;
          if (target == F_IGNORED) status_hold_next = ST_COMPLETE;
        end
      end
    end

    verdict = status_hold_next;
    if (item.frame_end && status_hold_next == ST_PARSING) verdict = ST_TRUNC;

    result.field_code = active ? field_now : F_IGNORED;
    result.data_out   = item.byte_present ? item.data_byte : 8'd0;
    result.item_index = (active && (field_now == F_SPLIT_ADDR || field_now == F_SPLIT_BP ||
                        field_now == F_TX_LEN || field_now == F_TX_BYTES)) ?
                        item_number : 32'd0;
    result.verdict    = verdict;
    result.frame_done = item.frame_end;

    // A frame end starts a new record with the next item.
    if (item.frame_end) begin
      field_now_next    = F_VERSION;
      byte_count_next   = 32'd0;
      length_hold_next  = 32'd0;
      version_hold_next = 32'd0;
      song_present_next = 1'b0;
      items_left_next   = 32'd0;
      splits_left_next  = 8'd0;
      item_number_next  = 32'd0;
      status_hold_next  = ST_PARSING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_now    <= F_VERSION;
      byte_count   <= 32'd0;
      length_hold  <= 32'd0;
      version_hold <= 32'd0;
      song_present <= 1'b0;
      items_left   <= 32'd0;
      splits_left  <= 8'd0;
      item_number  <= 32'd0;
      status_hold  <= ST_PARSING;
    end else if (step) begin
      field_now    <= field_now_next;
      byte_count   <= byte_count_next;
      length_hold  <= length_hold_next;
      version_hold <= version_hold_next;
      song_present <= song_present_next;
      items_left   <= items_left_next;
      splits_left  <= splits_left_next;
      item_number  <= item_number_next;
      status_hold  <= status_hold_next;
    end
  end

`ifndef SYNTHESIS
  a_done_is_ignored: assert property (@(posedge clk) disable iff (rst)
    status_hold != ST_PARSING |-> field_now == F_IGNORED)
    else $error("finished or failed record is still tagging fields");

  a_no_stored_trunc: assert property (@(posedge clk) disable iff (rst)
    status_hold != ST_TRUNC)
    else $error("truncation verdict was stored");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.frame_end |=>
      field_now == F_VERSION && status_hold == ST_PARSING && byte_count == 32'd0)
    else $error("parser not cleared after frame end");
`endif

endmodule

/* src/block_record_stream_parser_top.sv */
// Top level of the block record stream parser: input register, output register
// and the separator register around brsp_parse. Depends on brsp_pkg and brsp_parse.
//
//   Channel   Valid       Stall       Payload
//   input     byte_valid  byte_stall  byte_item (data_byte, byte_present, frame_end)
//   output    tag_valid   tag_stall   tag_item (field_code .. frame_done)
//   config    cfg_write_en            cfg_write_data (separator byte)
//
// One item per clock cycle unless tag_stall holds the output.
// All tagging for an item is combinational between input and output registers.
// Synchronous reset clears both valid flags, the parser state and the separator byte.
// While tag_stall holds the result, one more item waits in the input register.
module block_record_stream_parser_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  brsp_pkg::in_item_t  byte_item,
  output logic                tag_valid,
  input  logic                tag_stall,
  output brsp_pkg::out_item_t tag_item,
  input  logic                cfg_write_en,
  input  logic [7:0]          cfg_write_data
);
  import brsp_pkg::*;

  logic [7:0] separator_byte;
  logic       hold_valid;
  in_item_t   hold_item;
  out_item_t  result;
  logic       out_free;
  logic       step;

  assign out_free   = !tag_valid || !tag_stall;
  assign step       = hold_valid && out_free;
  assign byte_stall = hold_valid && !out_free;

  brsp_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .separator_byte (separator_byte),
    .item           (hold_item),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_byte <= 8'd0;
    end else if (cfg_write_en) begin
      separator_byte <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!byte_stall) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      hold_item <= byte_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else if (out_free) begin
      tag_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tag_item <= result;
    end
  end

endmodule

/* sim/block_record_stream_parser_top_tb.sv */
// Self-checking testbench for block_record_stream_parser_top: a table of directed records,
// then random well-formed and broken records, each result checked against a behavioral model or typed table row.
// Depends on brsp_pkg and the parser RTL; needs no files or arguments.
module block_record_stream_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brsp_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int PHASE_ITEMS     = 217;
  localparam int LONG_HOLD       = 60;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int N_ROWS          = 27;

  localparam logic [5:0] FC_PREV_HASH   = 6'd1;
  localparam logic [5:0] FC_MERKLE      = 6'd2;
  localparam logic [5:0] FC_FP_HASH     = 6'd3;
  localparam logic [5:0] FC_CONTENT     = 6'd4;
  localparam logic [5:0] FC_TIMESTAMP   = 6'd5;
  localparam logic [5:0] FC_BODY_HASH   = 6'd7;
  localparam logic [5:0] FC_SONG_HASH   = 6'd10;
  localparam logic [5:0] FC_DURATION    = 6'd13;
  localparam logic [5:0] FC_ARTIST_ADDR = 6'd18;
  localparam logic [5:0] FC_YEAR        = 6'd23;
  localparam logic [5:0] FC_TRACK       = 6'd24;

  typedef struct {
    logic [7:0] data;
    bit         present;
    bit         fend;
    int         reps;
    bit         typed;
    logic [5:0] code;
    logic [1:0] verdict;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  in_item_t    byte_item;
  logic        tag_valid;
  logic        tag_stall;
  out_item_t   tag_item;
  logic        cfg_write_en;
  logic [7:0]  cfg_write_data;

  logic        row_typed;
  out_item_t   row_exp;

  int          tx_idle_pct = 22;
  int          rx_idle_pct = 75;
  bit          hold_req = 1'b0;
  logic [7:0]  sep_setting = 8'h00;

  out_item_t   pending_tags[$];
  logic [7:0]  rec_bytes[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          items_in = 0;
  int          n_complete = 0;
  int          n_trunc = 0;
  int          n_bad_sep = 0;

  logic [5:0]  cur_field;
  logic [31:0] field_pos;
  logic [31:0] len_acc;
  logic [31:0] ver_acc;
  bit          song_on;
  logic [31:0] tx_remaining;
  logic [7:0]  splits_remaining;
  logic [31:0] entry_no;
  logic [1:0]  standing;
  logic [7:0]  sep_byte;

  step_row_t dir_rows [N_ROWS] = '{
    '{8'hFF, 1'b0, 1'b0,   1, 1'b1, F_IGNORED, ST_PARSING},
    '{8'hFF, 1'b1, 1'b0,   1, 1'b1, F_VERSION, ST_PARSING},
    '{8'h00, 1'b1, 1'b0,   3, 1'b0, F_VERSION, ST_PARSING},
    '{8'h00, 1'b1, 1'b0, 136, 1'b0, F_VERSION, ST_PARSING},
    '{8'h5A, 1'b1, 1'b0,  64, 1'b0, F_VERSION, ST_PARSING},
    '{8'h00, 1'b1, 1'b0,   1, 1'b0, F_VERSION, ST_PARSING},
    '{8'hC3, 1'b1, 1'b0,   4, 1'b0, F_VERSION, ST_PARSING},
    '{8'h02, 1'b1, 1'b0,   1, 1'b0, F_VERSION, ST_PARSING},
    '{8'h00, 1'b1, 1'b0,   3, 1'b0, F_VERSION, ST_PARSING},
    '{8'h00, 1'b1, 1'b0,   4, 1'b0, F_VERSION, ST_PARSING},
    '{8'h03, 1'b1, 1'b0,   1, 1'b0, F_VERSION, ST_PARSING},
    '{8'h00, 1'b1, 1'b0,   3, 1'b0, F_VERSION, ST_PARSING},
    '{8'hFF, 1'b1, 1'b0,   3, 1'b0, F_VERSION, ST_PARSING},
    '{8'h77, 1'b1, 1'b0,   1, 1'b1, F_IGNORED, ST_COMPLETE},
    '{8'h00, 1'b0, 1'b1,   1, 1'b1, F_IGNORED, ST_COMPLETE},
    '{8'h01, 1'b1, 1'b0,   1, 1'b1, F_VERSION, ST_PARSING},
    '{8'h00, 1'b1, 1'b1,   1, 1'b1, F_VERSION, ST_TRUNC},
    '{8'h03, 1'b1, 1'b0,   1, 1'b0, F_VERSION, ST_PARSING},
    '{8'h00, 1'b1, 1'b0,   3, 1'b0, F_VERSION, ST_PARSING},
    '{8'h11, 1'b1, 1'b0, 136, 1'b0, F_VERSION, ST_PARSING},
    '{8'h80, 1'b1, 1'b0,   1, 1'b0, F_VERSION, ST_PARSING},
    '{8'h09, 1'b1, 1'b0,   1, 1'b0, F_VERSION, ST_PARSING},
    '{8'h00, 1'b1, 1'b0,  71, 1'b0, F_VERSION, ST_PARSING},
    '{8'hC3, 1'b1, 1'b0,   2, 1'b0, F_VERSION, ST_PARSING},
    '{8'h3C, 1'b1, 1'b0,   1, 1'b1, F_SEP,     ST_BAD_SEP},
    '{8'hC3, 1'b1, 1'b0,   1, 1'b1, F_IGNORED, ST_BAD_SEP},
    '{8'hC3, 1'b1, 1'b1,   1, 1'b1, F_IGNORED, ST_BAD_SEP}
  };

  block_record_stream_parser_top dut (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .byte_item      (byte_item),
    .tag_valid      (tag_valid),
    .tag_stall      (tag_stall),
    .tag_item       (tag_item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [31:0] field_span(input logic [5:0] f);
    case (f)
      F_VERSION, FC_DURATION, F_TX_COUNT, F_TX_LEN: return 32'd4;
      FC_PREV_HASH, FC_MERKLE, FC_FP_HASH, FC_CONTENT, F_STATE_ROOT, FC_BODY_HASH,
      FC_SONG_HASH: return 32'd32;
      FC_TIMESTAMP: return 32'd8;
      F_FLAG, F_FORMAT, F_ROY_COUNT: return 32'd1;
      F_FP_LEN, F_TITLE_LEN, F_ARTIST_LEN, F_GENRE_LEN, F_ALBUM_LEN, FC_YEAR, FC_TRACK,
      F_SPLIT_BP: return 32'd2;
      FC_ARTIST_ADDR, F_SPLIT_ADDR: return 32'd20;
      F_SEP: return 32'(SEP_LEN);
      default: return 32'd0;
    endcase
  endfunction

  function automatic bit is_len_field(input logic [5:0] f);
    return f == F_FP_LEN || f == F_TITLE_LEN || f == F_ARTIST_LEN || f == F_GENRE_LEN ||
           f == F_ALBUM_LEN || f == F_TX_COUNT || f == F_TX_LEN;
  endfunction

  function automatic bit is_str_body(input logic [5:0] f);
    return f == F_FP_BYTES || f == F_TITLE || f == F_ARTIST || f == F_GENRE || f == F_ALBUM;
  endfunction

  task automatic clear_parse();
    cur_field = F_VERSION;
    field_pos = '0;
    len_acc = '0;
    ver_acc = '0;
    song_on = 1'b0;
    tx_remaining = '0;
    splits_remaining = '0;
    entry_no = '0;
    standing = ST_PARSING;
  endtask

  // Absent fields and zero-length bodies are skipped until a field that takes bytes or the record's end.
  task automatic advance_to(input logic [5:0] f);
    logic [5:0] nf;
    bit moving;
    nf = f;
    moving = 1'b1;
    while (moving) begin
      if (nf == F_STATE_ROOT && ver_acc < 32'd4) begin
        nf = F_FLAG;
      end else if (nf == F_FORMAT && !song_on) begin
        nf = F_SEP;
      end else if (is_str_body(nf) && len_acc == 0) begin
        nf = nf + 6'd1;
      end else if (nf == F_SPLIT_ADDR && splits_remaining == 0) begin
        nf = F_SEP;
      end else if (nf == F_TX_LEN && tx_remaining == 0) begin
        nf = F_IGNORED;
      end else if (nf == F_TX_BYTES && len_acc == 0) begin
        tx_remaining = tx_remaining - 1;
        entry_no = entry_no + 1;
        nf = F_TX_LEN;
      end else begin
        moving = 1'b0;
      end
    end
    cur_field = nf;
    field_pos = '0;
    if (nf == F_IGNORED) standing = ST_COMPLETE;
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [5:0]  f;
    logic [31:0] n;
    logic [31:0] wide;
    logic [31:0] span;
    f = cur_field;
    n = field_pos;
    wide = {24'h0, b};
    if (f == F_SEP && b != sep_byte) begin
      standing = ST_BAD_SEP;
      cur_field = F_IGNORED;
      return;
    end
    if (f == F_VERSION) ver_acc = (n == 0) ? wide : (ver_acc | (wide << ((8 * n) & 31)));
    if (is_len_field(f)) len_acc = (n == 0) ? wide : (len_acc | (wide << ((8 * n) & 31)));
    if (f == F_FLAG) song_on = (b != 8'h00);
    if (f == F_ROY_COUNT) splits_remaining = b;
    span = field_span(f);
    if (span == 0) span = len_acc;
    if (n + 1 < span) begin
      field_pos = n + 1;
      return;
    end
    case (f)
      F_ROY_COUNT: begin
        entry_no = '0;
        advance_to(F_SPLIT_ADDR);
      end
      F_SPLIT_BP: begin
        splits_remaining = splits_remaining - 8'd1;
        entry_no = entry_no + 1;
        advance_to(F_SPLIT_ADDR);
      end
      F_TX_COUNT: begin
        tx_remaining = len_acc;
        entry_no = '0;
        advance_to(F_TX_LEN);
      end
      F_TX_BYTES: begin
        tx_remaining = tx_remaining - 1;
        entry_no = entry_no + 1;
        advance_to(F_TX_LEN);
      end
      default: begin
        advance_to(f + 6'd1);
      end
    endcase
  endtask

  task automatic tag_byte(input in_item_t it, output out_item_t res);
    res.field_code = F_IGNORED;
    res.item_index = '0;
    if (it.byte_present && cur_field < F_IGNORED && standing == ST_PARSING) begin
      res.field_code = cur_field;
      if (cur_field == F_SPLIT_ADDR || cur_field == F_SPLIT_BP ||
          cur_field == F_TX_LEN || cur_field == F_TX_BYTES) begin
        res.item_index = entry_no;
      end
      take_byte(it.data_byte);
    end
    res.verdict = (it.frame_end && standing == ST_PARSING) ? ST_TRUNC : standing;
    res.data_out = it.byte_present ? it.data_byte : 8'h00;
    res.frame_done = it.frame_end;
    if (it.frame_end) clear_parse();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    bit moved;
    moved = 1'b0;
    if (rst) begin
      clear_parse();
      sep_byte = 8'h00;
    end else begin
      if (cfg_write_en) sep_byte = cfg_write_data;
      if (byte_valid && !byte_stall) begin
        tag_byte(byte_item, want);
        if (row_typed) want = row_exp;
        pending_tags.push_back(want);
        items_in++;
        moved = 1'b1;
      end
      if (tag_valid && !tag_stall) begin
        moved = 1'b1;
        if (pending_tags.size() == 0) begin
          $display("%0t ns: result with no item pending, expected none, got %h", $time,
                   tag_item);
          mismatch_count++;
        end else begin
          want = pending_tags.pop_front();
          check_field("field_code", want.field_code, tag_item.field_code);
          check_field("data_out", want.data_out, tag_item.data_out);
          check_field("item_index", want.item_index, tag_item.item_index);
          check_field("verdict", want.verdict, tag_item.verdict);
          check_field("frame_done", want.frame_done, tag_item.frame_done);
          if (want.frame_done) begin
            case (want.verdict)
              ST_COMPLETE: n_complete++;
              ST_TRUNC:    n_trunc++;
              ST_BAD_SEP:  n_bad_sep++;
              default: ;
            endcase
          end
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t ns: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // The long hold is counted here so the sender keeps offering items meanwhile.
  initial begin
    int hold_left;
    hold_left = 0;
    tag_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        tag_stall <= 1'b1;
      end else begin
        tag_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t exp_tag);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    row_typed <= typed;
    row_exp <= exp_tag;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  task automatic await_all_tags();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending_tags.size() != 0) @(posedge clk);
  endtask

  task automatic load_separator(input logic [7:0] value);
    await_all_tags();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    sep_setting = value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic push_le(input logic [31:0] value, input int nbytes);
    for (int i = 0; i < nbytes; i++) rec_bytes.push_back(value[8*i +: 8]);
  endtask

  task automatic push_noise(input int nbytes);
    for (int i = 0; i < nbytes; i++) rec_bytes.push_back(8'($urandom));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 0;
    if (r < 90) return $urandom_range(1, 6);
    return $urandom_range(7, 40);
  endfunction

  task automatic push_string();
    int n;
    n = pick_len();
    push_le(n, 2);
    push_noise(n);
  endtask

  // Mostly clean records; the rest are cut short, carry an oversized transaction
  // count, break the separator run, or are plain noise.
  task automatic build_record(output int body_len);
    int kind;
    int r;
    int sep_at;
    int n_split;
    int n_tx;
    int n;
    int cut;
    logic [31:0] ver;
    logic [31:0] count;
    rec_bytes.delete();
    kind = $urandom_range(99);
    if (kind >= 92) begin
      push_noise($urandom_range(1, 12));
      body_len = rec_bytes.size();
      return;
    end
    r = $urandom_range(99);
    ver = (r < 40) ? $urandom_range(0, 3) : (r < 80) ? $urandom_range(4, 9) : $urandom;
    push_le(ver, 4);
    push_noise(136);
    if (ver >= 4) push_noise(64);
    if ($urandom_range(1) == 1) begin
      push_le($urandom_range(1, 255), 1);
      push_noise(33);
      push_string();
      push_noise(4);
      push_string();
      push_string();
      push_noise(20);
      push_string();
      push_string();
      push_noise(4);
      n_split = $urandom_range(0, 3);
      push_le(n_split, 1);
      for (int i = 0; i < n_split; i++) push_noise(22);
    end else begin
      push_le(0, 1);
    end
    sep_at = rec_bytes.size();
    for (int i = 0; i < SEP_LEN; i++) rec_bytes.push_back(sep_setting);
    n_tx = $urandom_range(0, 3);
    count = (kind >= 80 && kind < 86) ? ($urandom | 32'h10) : n_tx;
    push_le(count, 4);
    for (int i = 0; i < n_tx; i++) begin
      n = pick_len();
      push_le(n, 4);
      push_noise(n);
    end
    body_len = rec_bytes.size();
    if (kind >= 70 && kind < 80) begin
      cut = $urandom_range(1, rec_bytes.size() - 1);
      while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
      body_len = cut;
    end else if (kind >= 86) begin
      n = sep_at + $urandom_range(0, SEP_LEN - 1);
      rec_bytes[n] = rec_bytes[n] ^ 8'($urandom_range(1, 255));
    end else if (kind < 70 && $urandom_range(3) == 0) begin
      push_noise($urandom_range(1, 5));
    end
  endtask

  task automatic send_record();
    in_item_t it;
    bit end_marker;
    end_marker = ($urandom_range(6) == 0);
    foreach (rec_bytes[i]) begin
      if ($urandom_range(15) == 0) begin
        it.data_byte = 8'($urandom);
        it.byte_present = 1'b0;
        it.frame_end = 1'b0;
        send_item(it, 1'b0, '0);
      end
      it.data_byte = rec_bytes[i];
      it.byte_present = 1'b1;
      it.frame_end = !end_marker && (i == rec_bytes.size() - 1);
      send_item(it, 1'b0, '0);
    end
    if (end_marker) begin
      it.data_byte = 8'($urandom);
      it.byte_present = 1'b0;
      it.frame_end = 1'b1;
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input logic [7:0] sep,
                           input bit pressure);
    int done_items;
    int body;
    int frames;
    load_separator(sep);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    done_items = 0;
    frames = 0;
    if (pressure) hold_req = 1'b1;
    while (done_items < PHASE_ITEMS) begin
      build_record(body);
      send_record();
      done_items += body;
      frames++;
      if (pressure && frames == 1) await_all_tags();
    end
  endtask

  initial begin
    in_item_t   it;
    out_item_t  typed_tag;
    logic [7:0] sep_last;
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_item = '0;
    row_typed = 1'b0;
    row_exp = '0;
    cfg_write_en = 1'b0;
    cfg_write_data = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    load_separator(8'hC3);
    for (int r = 0; r < N_ROWS; r++) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        it.data_byte = dir_rows[r].data;
        it.byte_present = dir_rows[r].present;
        it.frame_end = dir_rows[r].fend;
        typed_tag.field_code = dir_rows[r].code;
        typed_tag.data_out = dir_rows[r].present ? dir_rows[r].data : 8'h00;
        typed_tag.item_index = '0;
        typed_tag.verdict = dir_rows[r].verdict;
        typed_tag.frame_done = dir_rows[r].fend;
        send_item(it, dir_rows[r].typed, typed_tag);
      end
    end

    run_phase(22, 75, 8'hFF, 1'b0);
    run_phase(75, 22, 8'h00, 1'b0);
    sep_last = 8'($urandom_range(1, 254));
    run_phase(0, 0, sep_last, 1'b1);

    await_all_tags();
    repeat (8) @(posedge clk);
    if (pending_tags.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_tags.size());
      mismatch_count++;
    end
    $display("Checked %0d items in frames ending complete %0d, truncated %0d, bad separator %0d.",
             items_in, n_complete, n_trunc, n_bad_sep);
    $display("Separator bytes c3, ff, 00 and %02h were used under three idle patterns.",
             sep_last);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/brsp_pkg.sv
src/brsp_parse.sv
src/block_record_stream_parser_top.sv
sim/block_record_stream_parser_top_tb.sv
